/* rtl/fwrl_pkg.sv */
package fwrl_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] event_id;
        logic [31:0] limit;
        logic [31:0] window;
        logic [31:0] amount;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic       exceeded;
        logic       status;
        logic [8:0] removed;
        logic       wrapped;
    } rsp_t;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_SWEEP = 1'b1;

    localparam logic [8:0] SWEEP_BATCH_RESET = 9'd16;

endpackage

/* rtl/fwrl_if.sv */
interface fwrl_req_if;
    logic             valid;
    logic             ready;
    fwrl_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fwrl_rsp_if;
    logic             valid;
    logic             ready;
    fwrl_pkg::rsp_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/fwrl_slot_mem.sv */
// Slot storage: one write port, one registered read port.
module fwrl_slot_mem #(
    parameter int SLOTS = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [159:0]  rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [159:0]  wr_data
);
    logic [159:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/fixed_window_rate_limit_table_top.sv */
// Fixed-window rate-limit table.
// Check: scans every slot, one per cycle (read pipeline), then an update
//   state writes the slot and an output state gives the result. Sweep: scans
//   from the cursor and stops early when the batch is used up at a valid slot.
// One item at a time; input is ready again the cycle after the result is taken.
// Reset (rst_n, async low) clears valid bits, cursor and control, sets batch to 16;
//   slot contents are undefined until written and need no clearing pass.
module fixed_window_rate_limit_table_top #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    fwrl_req_if.sink   req,
    fwrl_rsp_if.source rsp
);
    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_SWP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [8:0]          batch_reg;
    fwrl_pkg::req_t      req_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [CW-1:0]       addr_reg;      // next read issue index
    logic                pend_reg;      // read data pending
    logic [AW-1:0]       pidx_reg;      // index of pending read
    logic                hit_reg, free_reg;
    logic [AW-1:0]       hidx_reg, fidx_reg;
    logic [159:0]        hdata_reg;
    logic [AW-1:0]       cursor_reg;
    logic [8:0]          exam_reg;
    logic [8:0]          rem_reg;
    logic                stop_reg;
    fwrl_pkg::rsp_t      out_reg;
    logic                ov_reg;

    logic [AW-1:0] rd_addr;
    logic [159:0]  rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [159:0]  wr_data;

    fwrl_slot_mem #(.SLOTS(TABLE_SLOTS), .AW(AW)) u_mem (
        .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    // slot record: event, limit, window, start, count
    logic [31:0] m_ev, m_lim, m_win, m_st, m_cnt, age;
    assign {m_ev, m_lim, m_win, m_st, m_cnt} = rd_data;
    assign age = req_reg.now - m_st;
    assign rd_addr = addr_reg[AW-1:0];

    // update arithmetic on the held hit record
    logic [31:0] h_st, h_cnt, h_age, new_cnt;
    logic [32:0] sum;
    assign h_st  = hdata_reg[63:32];
    assign h_cnt = hdata_reg[31:0];
    assign h_age = req_reg.now - h_st;
    assign sum   = {1'b0, h_cnt} + {1'b0, req_reg.amount};
    always_comb
    begin
        if (hit_reg && (h_age < req_reg.window))
            new_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        else
            new_cnt = req_reg.amount;
    end
    // existing entry is rewritten in place, a new key goes to the first free slot
    assign wr_addr = hit_reg ? hidx_reg : fidx_reg;
    assign wr_en = (state_reg == ST_UPD) && (hit_reg || free_reg);
    assign wr_data = {req_reg.event_id, req_reg.limit, req_reg.window,
                      (hit_reg && (h_age < req_reg.window)) ? h_st : req_reg.now,
                      new_cnt};

    assign req.ready = (state_reg == ST_IDLE) && !ov_reg;
    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;

    logic scan_done;
    assign scan_done = (addr_reg == CW'(TABLE_SLOTS)) && !pend_reg;

    // sweep reaches a valid slot with the batch used up
    logic swp_stop;
    assign swp_stop = pend_reg && !stop_reg && valid_reg[pidx_reg] &&
                      (exam_reg >= batch_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (req.valid && !ov_reg)
                state_next = (req.data.kind == fwrl_pkg::KIND_SWEEP) ? ST_SWP : ST_SCAN;
            ST_SCAN: if (scan_done) state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_SWP:  if (stop_reg || scan_done) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            batch_reg  <= fwrl_pkg::SWEEP_BATCH_RESET;
            valid_reg  <= '0;
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            addr_reg   <= '0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                batch_reg <= cfg_wdata;
            end
            if (ov_reg && rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && !ov_reg)
                    begin
                        req_reg  <= req.data;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                        exam_reg <= '0;
                        rem_reg  <= '0;
                        stop_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        addr_reg <= (req.data.kind == fwrl_pkg::KIND_SWEEP)
                                    ? {1'b0, cursor_reg} : '0;
                    end
                end
                ST_SCAN:
                begin
                    // issue one read per cycle, compare the returned one
                    pend_reg <= (addr_reg != CW'(TABLE_SLOTS));
                    pidx_reg <= addr_reg[AW-1:0];
                    if (addr_reg != CW'(TABLE_SLOTS))
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        if (valid_reg[pidx_reg])
                        begin
                            if (!hit_reg && m_ev == req_reg.event_id &&
                                m_lim == req_reg.limit && m_win == req_reg.window)
                            begin
                                hit_reg   <= 1'b1;
                                hidx_reg  <= pidx_reg;
                                hdata_reg <= rd_data;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_reg <= 1'b1;
                            fidx_reg <= pidx_reg;
                        end
                    end
                end
                ST_UPD:
                begin
                    out_reg.removed <= '0;
                    out_reg.wrapped <= 1'b0;
                    if (hit_reg || free_reg)
                    begin
                        out_reg.status   <= 1'b0;
                        out_reg.exceeded <= (new_cnt > req_reg.limit);
                    end
                    else
                    begin
                        out_reg.status   <= 1'b1;
                        out_reg.exceeded <= (req_reg.amount > req_reg.limit);
                    end
                    if (!hit_reg && free_reg)
                    begin
                        valid_reg[fidx_reg] <= 1'b1;
                    end
                end
                ST_SWP:
                begin
                    pend_reg <= (addr_reg != CW'(TABLE_SLOTS)) && !stop_reg && !swp_stop;
                    pidx_reg <= addr_reg[AW-1:0];
                    if (addr_reg != CW'(TABLE_SLOTS))
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                    if (pend_reg && !stop_reg && valid_reg[pidx_reg])
                    begin
                        if (swp_stop)
                        begin
                            stop_reg   <= 1'b1;
                            cursor_reg <= pidx_reg;
                        end
                        else
                        begin
                            exam_reg <= exam_reg + 1'b1;
                            if (age > m_win)
                            begin
                                valid_reg[pidx_reg] <= 1'b0;
                                rem_reg <= rem_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_OUT:
                begin
                    ov_reg <= 1'b1;
                    if (req_reg.kind == fwrl_pkg::KIND_SWEEP)
                    begin
                        out_reg.exceeded <= 1'b0;
                        out_reg.status   <= 1'b0;
                        out_reg.removed  <= rem_reg;
                        out_reg.wrapped  <= !stop_reg;
                        if (!stop_reg)
                        begin
                            cursor_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/fwrl_checker.sv */
module fwrl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_status,
    input logic       rsp_exceeded,
    input logic [8:0] rsp_removed,
    input logic       rsp_end
);
    a_sweep_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_removed != 9'd0) |-> !rsp_status && !rsp_exceeded)
        else $error("sweep result carries check flags");
    a_check_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_removed == 9'd0 && !rsp_end)
        else $error("check result carries sweep fields");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("accepted while busy");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped");
endmodule

bind fixed_window_rate_limit_table_top fwrl_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.data.status), .rsp_exceeded(rsp.data.exceeded),
    .rsp_removed(rsp.data.removed), .rsp_end(rsp.data.wrapped)
);

/* tb/tb_fixed_window_rate_limit_table_top.sv */
`timescale 1ns / 100ps

module tb_fixed_window_rate_limit_table_top;

    localparam int SLOTS = 256;
    localparam int STALL_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    fwrl_req_if req_ch ();
    fwrl_rsp_if rsp_ch ();

    fixed_window_rate_limit_table_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // Shadow copy of the limiter table
    logic [8:0]  batch_sh;
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_event [SLOTS];
    logic [31:0] tbl_limit [SLOTS];
    logic [31:0] tbl_window [SLOTS];
    logic [31:0] tbl_start [SLOTS];
    logic [31:0] tbl_count [SLOTS];
    int          cursor_sh;

    fwrl_pkg::req_t pending_items [$];
    fwrl_pkg::rsp_t expected_rsp [$];
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   hold_off = 0;
    int   send_gap = 0;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;

    // Time base and key pool so that checks revisit entries
    logic [31:0] clock_now;
    logic [31:0] key_ev [16];
    logic [31:0] key_lim [16];
    logic [31:0] key_win [16];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic fwrl_pkg::rsp_t limiter_predict(fwrl_pkg::req_t it);
        fwrl_pkg::rsp_t r;
        int hit;
        int free_slot;
        int s;
        int examined;
        bit ended;
        logic [32:0] sum;
        r = '0;
        if (it.kind == fwrl_pkg::KIND_SWEEP)
        begin
            examined = 0;
            ended = 1'b1;
            for (s = cursor_sh; s < SLOTS; s++)
            begin
                if (tbl_valid[s])
                begin
                    if (examined >= batch_sh)
                    begin
                        ended = 1'b0;
                        break;
                    end
                    examined++;
                    if (it.now - tbl_start[s] > tbl_window[s])
                    begin
                        tbl_valid[s] = 1'b0;
                        r.removed = r.removed + 9'd1;
                    end
                end
            end
            cursor_sh = ended ? 0 : s;
            r.wrapped = ended;
            return r;
        end
        hit = -1;
        free_slot = -1;
        for (s = 0; s < SLOTS; s++)
        begin
            if (tbl_valid[s])
            begin
                if (hit < 0 && tbl_event[s] == it.event_id && tbl_limit[s] == it.limit
                    && tbl_window[s] == it.window)
                    hit = s;
            end
            else if (free_slot < 0)
                free_slot = s;
        end
        if (hit < 0)
        begin
            if (free_slot < 0)
            begin
                r.exceeded = it.amount > it.limit;
                r.status = 1'b1;
                return r;
            end
            hit = free_slot;
            tbl_valid[hit] = 1'b1;
            tbl_event[hit] = it.event_id;
            tbl_limit[hit] = it.limit;
            tbl_window[hit] = it.window;
            tbl_start[hit] = it.now;
            tbl_count[hit] = it.amount;
        end
        else if (it.now - tbl_start[hit] < it.window)
        begin
            sum = {1'b0, tbl_count[hit]} + {1'b0, it.amount};
            tbl_count[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        else
        begin
            tbl_start[hit] = it.now;
            tbl_count[hit] = it.amount;
        end
        r.exceeded = tbl_count[hit] > it.limit;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic queue_item(fwrl_pkg::req_t it);
        pending_items = {pending_items, it};
    endtask

    // Driver: one item from the queue at a time, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
            send_gap <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() > 0 && $urandom_range(0, 99) < 75)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data <= pending_items[0];
                expected_rsp = {expected_rsp, limiter_predict(pending_items[0])};
                void'(pending_items.pop_front());
            end
            else
            begin
                req_ch.valid <= 1'b0;
                if ($urandom_range(0, 99) < 3)
                    send_gap <= $urandom_range(10, 200);
            end
        end
    end

    // Receiver stalls: short mostly, some long, plus forced hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_off <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            rsp_ch.ready <= 1'b0;
            hold_off <= 500;
            hold_done <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if ($urandom_range(0, 99) < 3)
            hold_off <= $urandom_range(10, 300);
        else
            rsp_ch.ready <= $urandom_range(0, 99) < 70;
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected result", 32'(rsp_ch.data), 32'd0);
                else
                begin
                    if (rsp_ch.data.exceeded !== expected_rsp[0].exceeded)
                        report_mismatch("exceeded", 32'(rsp_ch.data.exceeded),
                                        32'(expected_rsp[0].exceeded));
                    if (rsp_ch.data.status !== expected_rsp[0].status)
                        report_mismatch("status", 32'(rsp_ch.data.status),
                                        32'(expected_rsp[0].status));
                    if (rsp_ch.data.removed !== expected_rsp[0].removed)
                        report_mismatch("removed", 32'(rsp_ch.data.removed),
                                        32'(expected_rsp[0].removed));
                    if (rsp_ch.data.wrapped !== expected_rsp[0].wrapped)
                        report_mismatch("wrapped", 32'(rsp_ch.data.wrapped),
                                        32'(expected_rsp[0].wrapped));
                    void'(expected_rsp.pop_front());
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (!req_ch.valid && expected_rsp.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("fixed_window_rate_limit_table_top verification failed");
                $finish;
            end
        end
    end

    function automatic fwrl_pkg::req_t make_check(logic [31:0] ev, logic [31:0] lim,
                                                  logic [31:0] win, logic [31:0] amt,
                                                  logic [31:0] t);
        fwrl_pkg::req_t it;
        it.kind = fwrl_pkg::KIND_CHECK;
        it.event_id = ev;
        it.limit = lim;
        it.window = win;
        it.amount = amt;
        it.now = t;
        return it;
    endfunction

    function automatic fwrl_pkg::req_t make_sweep(logic [31:0] t);
        fwrl_pkg::req_t it;
        it = '0;
        it.kind = fwrl_pkg::KIND_SWEEP;
        it.event_id = $urandom();
        it.limit = $urandom();
        it.window = $urandom();
        it.amount = $urandom();
        it.now = t;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || req_ch.valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (SLOTS + 20) @(posedge clk);
    endtask

    task automatic write_batch(logic [8:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        batch_sh = val;
    endtask

    // Random phase: mostly repeated keys, some fresh, some sweeps
    task automatic random_phase(int n);
        int k;
        int i;
        for (i = 0; i < n; i++)
        begin
            clock_now += $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 5);
            k = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0: queue_item(make_sweep(clock_now));
                1: queue_item(make_check($urandom(), $urandom(), $urandom(),
                                         $urandom(), $urandom()));
                default: queue_item(make_check(key_ev[k], key_lim[k],
                    key_win[k], $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 9),
                    clock_now));
            endcase
        end
    endtask

    initial
    begin
        int i;
        clock_now = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        batch_sh = fwrl_pkg::SWEEP_BATCH_RESET;
        cursor_sh = 0;
        for (i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        for (i = 0; i < 16; i++)
        begin
            key_ev[i] = i < 2 ? 32'hFFFF_FFFF * i : $urandom();
            key_lim[i] = i < 4 ? 32'hFFFF_FFFF * (i % 2) : $urandom_range(0, 40);
            key_win[i] = i < 6 ? 32'hFFFF_FFFF * (i % 2) : $urandom_range(1, 20);
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, saturation, window restart, empty sweep
        queue_item(make_sweep(0));
        queue_item(make_check(0, 0, 0, 0, 0));
        queue_item(make_check(0, 0, 0, 1, 0));
        queue_item(make_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_item(make_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'h0000_0005));
        queue_item(make_check(7, 10, 100, 6, 1000));
        queue_item(make_check(7, 10, 100, 5, 1099));
        queue_item(make_check(7, 10, 100, 3, 1100));
        queue_item(make_check(7, 10, 100, 32'hFFFF_FFF0, 1101));
        queue_item(make_check(7, 10, 100, 32'hFFFF_FFF0, 1102));
        queue_item(make_sweep(1150));
        queue_item(make_sweep(32'hFFFF_0000));
        queue_item(make_sweep(32'hFFFF_0000));
        wait_drained();

        // Hold the receiver off while the sender keeps offering
        hold_req = 1'b1;
        clock_now = 5000;
        random_phase(150);
        wait_drained();

        // Fill the table beyond capacity with batch extremes on sweeps
        write_batch(9'd0);
        for (i = 0; i < SLOTS + 6; i++)
            queue_item(make_check($urandom(), $urandom(), 5, $urandom(), 6000));
        queue_item(make_sweep(6001));
        queue_item(make_sweep(6001));
        wait_drained();
        write_batch(9'd1);
        for (i = 0; i < 4; i++)
            queue_item(make_sweep(7000));
        wait_drained();
        write_batch(9'h1FF);
        queue_item(make_sweep(7000));
        queue_item(make_sweep(7000));
        wait_drained();

        write_batch(9'd256);
        clock_now = 8000;
        random_phase(200);
        wait_drained();
        write_batch(9'd3);
        random_phase(200);
        wait_drained();
        write_batch(9'd16);
        random_phase(200);
        wait_drained();

        if (fail_count == 0)
            $display("fixed_window_rate_limit_table_top verification clean");
        else
            $display("fixed_window_rate_limit_table_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fwrl_pkg.sv
rtl/fwrl_if.sv
rtl/fwrl_slot_mem.sv
rtl/fixed_window_rate_limit_table_top.sv
rtl/fwrl_checker.sv
tb/tb_fixed_window_rate_limit_table_top.sv
